### design/assert_macros.svh
// shared assertion macros for the pixelate block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pxl_pkg.sv
package pxl_pkg;

	localparam int MAX_LINE_WIDTH = 4096;
	localparam int MAX_BLOCK = 64;

	localparam int COL_W = $clog2(MAX_LINE_WIDTH);
	localparam int SIZE_W = COL_W + 1;
	localparam int CIB_W = $clog2(MAX_BLOCK);
	localparam int BSIZE_W = CIB_W + 1;
	localparam int PIX_W = 24;

	localparam int ADDR_W = 5;

	// register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BLOCK_WIDTH = 3'd2;
	localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd3;
	localparam logic [2:0] REG_PIXEL_DEPTH = 3'd4;

	// depth selections
	localparam logic [1:0] DEPTH_8 = 2'd0;
	localparam logic [1:0] DEPTH_16 = 2'd1;
	localparam logic [1:0] DEPTH_24 = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             frame_start;
	} pxl_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             line_end;
		logic             frame_end;
	} pxl_out_t;

	// sizes after clamping, ready for the datapath
	typedef struct packed {
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [BSIZE_W-1:0] blk_w;
		logic [BSIZE_W-1:0] blk_h;
		logic [1:0]         depth;
	} pxl_cfg_t;

	function automatic logic [PIX_W-1:0] apply_depth(input logic [PIX_W-1:0] v,
		input logic [1:0] sel);
		logic [PIX_W-1:0] r;
		case (sel)
			DEPTH_24: r = v;
			DEPTH_16: r = {8'd0, v[15:0]};
			default: r = {16'd0, v[7:0]};
		endcase
		return r;
	endfunction

endpackage

### design/pxl_regs.sv
module pxl_regs import pxl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output pxl_cfg_t          cfg
);

	logic [SIZE_W-1:0]  image_width_q;
	logic [SIZE_W-1:0]  image_height_q;
	logic [BSIZE_W-1:0] block_width_q;
	logic [BSIZE_W-1:0] block_height_q;
	logic [4:0]         pixel_depth_q;
	logic               wr_en;
	logic [2:0]         reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= SIZE_W'(640);
			image_height_q <= SIZE_W'(480);
			block_width_q <= BSIZE_W'(4);
			block_height_q <= BSIZE_W'(4);
			pixel_depth_q <= 5'd24;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IMAGE_WIDTH: image_width_q <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[SIZE_W-1:0];
				REG_BLOCK_WIDTH: block_width_q <= pwdata[BSIZE_W-1:0];
				REG_BLOCK_HEIGHT: block_height_q <= pwdata[BSIZE_W-1:0];
				REG_PIXEL_DEPTH: pixel_depth_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH: prdata = {{(32-SIZE_W){1'b0}}, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, image_height_q};
			REG_BLOCK_WIDTH: prdata = {{(32-BSIZE_W){1'b0}}, block_width_q};
			REG_BLOCK_HEIGHT: prdata = {{(32-BSIZE_W){1'b0}}, block_height_q};
			REG_PIXEL_DEPTH: prdata = {27'd0, pixel_depth_q};
			default: prdata = 32'd0;
		endcase
	end

	// for the sizes, zero acts as one and oversize acts as the maximum; depth maps to 24, 16 or 8 bits
	always_comb begin
		if (image_width_q == '0)
			cfg.width = SIZE_W'(1);
		else if (image_width_q > SIZE_W'(MAX_LINE_WIDTH))
			cfg.width = SIZE_W'(MAX_LINE_WIDTH);
		else
			cfg.width = image_width_q;

		if (image_height_q == '0)
			cfg.height = SIZE_W'(1);
		else if (image_height_q > SIZE_W'(MAX_LINE_WIDTH))
			cfg.height = SIZE_W'(MAX_LINE_WIDTH);
		else
			cfg.height = image_height_q;

		if (block_width_q == '0)
			cfg.blk_w = BSIZE_W'(1);
		else if (block_width_q > BSIZE_W'(MAX_BLOCK))
			cfg.blk_w = BSIZE_W'(MAX_BLOCK);
		else
			cfg.blk_w = block_width_q;

		if (block_height_q == '0)
			cfg.blk_h = BSIZE_W'(1);
		else if (block_height_q > BSIZE_W'(MAX_BLOCK))
			cfg.blk_h = BSIZE_W'(MAX_BLOCK);
		else
			cfg.blk_h = block_height_q;

		if (pixel_depth_q >= 5'd24)
			cfg.depth = DEPTH_24;
		else if (pixel_depth_q >= 5'd16)
			cfg.depth = DEPTH_16;
		else
			cfg.depth = DEPTH_8;
	end

endmodule

### design/image_block_pixelate.sv
// Mosaic filter over a raster pixel stream: every output pixel carries the
// top-left pixel of its block_width x block_height block, masked to the pixel
// depth, with line_end and frame_end flags. One pixel is taken per clock while
// src_stall is low. An accepted pixel is registered in stage one, then moves
// into the output register; it waits in stage one while the output is stalled.
// The top row of each band of blocks writes its block samples into a
// one-port line store (one entry per column); the lower rows of the band read
// them back with a registered read in stage one. No clearing pass follows
// reset.
module image_block_pixelate import pxl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  pxl_in_t           src_data,
	output logic              dst_valid,
	input  logic              dst_stall,
	output pxl_out_t          dst_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	pxl_cfg_t cfg;

	pxl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [PIX_W-1:0] line_mem [MAX_LINE_WIDTH];

	logic [COL_W-1:0] col_q, row_q;
	logic [CIB_W-1:0] cib_q, rib_q;
	logic [PIX_W-1:0] held_q;

	logic [COL_W-1:0] col, row;
	logic [CIB_W-1:0] cib, rib;
	logic             accept, s2_ready, first_row, last_col, last_row;
	logic [PIX_W-1:0] sample;

	logic             valid_s1, from_mem_s1, line_end_s1, frame_end_s1;
	logic [PIX_W-1:0] value_s1, rd_s1;
	logic [PIX_W-1:0] result;

	logic             dst_valid_q;
	pxl_out_t         dst_data_q;

	assign s2_ready = !dst_valid_q || !dst_stall;
	assign src_stall = valid_s1 && !s2_ready;
	assign accept = src_valid && !src_stall;

	// frame start clears the counters before the pixel is placed
	assign col = src_data.frame_start ? '0 : col_q;
	assign row = src_data.frame_start ? '0 : row_q;
	assign cib = src_data.frame_start ? '0 : cib_q;
	assign rib = src_data.frame_start ? '0 : rib_q;

	assign first_row = (rib == '0);
	assign sample = (cib == '0) ? src_data.pixel_in : held_q;
	assign last_col = ({1'b0, col} + SIZE_W'(1)) >= cfg.width;
	assign last_row = ({1'b0, row} + SIZE_W'(1)) >= cfg.height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (first_row && cib == '0)
				held_q <= src_data.pixel_in;
			if (last_col) begin
				col_q <= '0;
				cib_q <= '0;
				if (last_row) begin
					row_q <= '0;
					rib_q <= '0;
				end else begin
					row_q <= row + COL_W'(1);
					if (({1'b0, rib} + BSIZE_W'(1)) >= cfg.blk_h)
						rib_q <= '0;
					else
						rib_q <= rib + CIB_W'(1);
				end
			end else begin
				col_q <= col + COL_W'(1);
				row_q <= row;
				rib_q <= rib;
				if (({1'b0, cib} + BSIZE_W'(1)) >= cfg.blk_w)
					cib_q <= '0;
				else
					cib_q <= cib + CIB_W'(1);
			end
		end
	end

	// writes happen in the top row of a band, reads in later rows, so a column
	// is never read in the same cycle it is written
	always_ff @(posedge clk) begin
		if (accept) begin
			if (first_row)
				line_mem[col] <= sample;
			else
				rd_s1 <= line_mem[col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (s2_ready)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_mem_s1 <= !first_row;
			value_s1 <= sample;
			line_end_s1 <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	assign result = apply_depth(from_mem_s1 ? rd_s1 : value_s1, cfg.depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dst_valid_q <= 1'b0;
		else if (s2_ready)
			dst_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			dst_data_q.pixel_out <= result;
			dst_data_q.line_end <= line_end_s1;
			dst_data_q.frame_end <= frame_end_s1;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data = dst_data_q;

endmodule

### design/pxl_chk.sv
`include "assert_macros.svh"

module pxl_chk import pxl_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     src_valid,
	input logic     src_stall,
	input logic     dst_valid,
	input logic     dst_stall,
	input pxl_out_t dst_data,
	input logic     pready
);

	// a waiting result keeps its content until taken
	`ASSERT_CLK(a_dst_hold, dst_valid && dst_stall |=> dst_valid && $stable(dst_data), "result changed while stalled")

	// the input only backs up behind a stalled result
	`ASSERT_CLK(a_stall_cause, src_stall |-> dst_valid && dst_stall, "input stalled with output free")

	// the last pixel of a frame is also the last of its line
	`ASSERT_CLK(a_frame_line, dst_valid |-> !dst_data.frame_end || dst_data.line_end, "frame_end without line_end")

	// the register port never waits
	`ASSERT_ALWAYS(a_pready, pready, "pready low")

	// an accepted request shows up as a valid result when the output stays free on its way through
	`ASSERT_CLK(a_latency, src_valid && !src_stall && !dst_stall ##1 !dst_stall |=> dst_valid, "result missing")

endmodule

bind image_block_pixelate pxl_chk u_pxl_chk (.*);
